/* design/dedup_moving_average_runtime_defines.svh */
// assertion macros for the runtime averaging block
`ifndef DEDUP_MOVING_AVERAGE_RUNTIME_DEFINES_SVH
`define DEDUP_MOVING_AVERAGE_RUNTIME_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DMAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DMAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dmar_pkg.sv */
// shared types and constants of the runtime averaging block
package dmar_pkg;

  localparam int unsigned PCT_W    = 8;
  localparam int unsigned SECS_W   = 25;
  localparam int unsigned SECS_MAG_W = 24;
  localparam int unsigned MIN_W    = 19;
  localparam int unsigned HRS_W    = 13;
  localparam int unsigned MINS_W   = 6;
  localparam int unsigned STATUS_W = 2;

  // floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for x below 2**24
  localparam int unsigned RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_60 = 25'd17895698;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned PROD_W      = SECS_MAG_W + RECIP_W;

  localparam logic [STATUS_W-1:0] STATUS_AVG      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHARGING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNAVAIL  = 2'd2;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

/* design/dedup_moving_average_runtime.sv */
// Averages battery runtime readings in minutes over a ring of the last WINDOW_DEPTH
// values, where a value equal to the newest entry is not added again, and reports the
// mean as hours and minutes. A failed reading answers unavailable and a charging reading
// (sign bit set) answers charging, both without touching the history. A runtime reading
// passes through the minutes conversion, the history update, the bit-serial divide of
// the running sum by the entry count and the hours split. One item is in work at a
// time; the next is taken as soon as the result sits in the output register.
`include "dedup_moving_average_runtime_defines.svh"

module dedup_moving_average_runtime #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // charge_percent, runtime_seconds, zero pad
  input  logic [0:0]  s_axis_tuser,  // reading_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // percent_out, avg_hours, avg_minutes, zero pad
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int unsigned MIN_W  = dmar_pkg::MIN_W;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = MIN_W + CNT_W;
  localparam int unsigned PCT_W  = dmar_pkg::PCT_W;
  localparam int unsigned HRS_W  = dmar_pkg::HRS_W;
  localparam int unsigned MAG_W  = dmar_pkg::SECS_MAG_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MINS = 4'd1;
  localparam logic [3:0] ST_RDOL = 4'd2;
  localparam logic [3:0] ST_UPD  = 4'd3;
  localparam logic [3:0] ST_DIVS = 4'd4;
  localparam logic [3:0] ST_DIVW = 4'd5;
  localparam logic [3:0] ST_HRS  = 4'd6;
  localparam logic [3:0] ST_OUT  = 4'd7;

  logic [3:0]          state_q, state_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;

  logic [MAG_W-1:0]    secs_q, secs_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  logic [1:0]          status_q, status_d;
  logic [MIN_W-1:0]    mins_q, mins_d;
  logic [MIN_W-1:0]    newest_q, newest_d;
  logic [MIN_W-1:0]    avg_q, avg_d;
  logic [HRS_W-1:0]    hours_q, hours_d;

  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_data_q, out_data_d;
  logic [1:0]          out_user_q, out_user_d;

  logic [MIN_W-1:0]    ring_mem [WINDOW_DEPTH];
  logic [MIN_W-1:0]    rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;

  logic [MAG_W-1:0]    mul_a;
  logic [dmar_pkg::PROD_W-1:0] product;
  logic [MIN_W-1:0]    hrs_x60;
  logic [MIN_W-1:0]    min_rem;
  logic [IDX_W-1:0]    tail_inc, tail_dec;
  logic                full, push, accept, out_load;

  dmar_pkg::div_ctrl_t   div_ctrl;
  logic [SUM_W-1:0]    div_quo;

  dmar_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctrl.start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_ctrl.done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(WINDOW_DEPTH));
  assign tail_inc      = (tail_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_dec      = (tail_q == '0) ? IDX_W'(WINDOW_DEPTH - 1) : tail_q - 1'b1;
  assign push          = (count_q == '0) || (newest_q != mins_q);

  assign mul_a   = (state_q == ST_MINS) ? secs_q : {{(MAG_W - MIN_W){1'b0}}, avg_q};
  assign product = mul_a * dmar_pkg::RECIP_60;
  assign hrs_x60 = MIN_W'({hours_q, 6'b0} - {hours_q, 2'b0});
  assign min_rem = avg_q - hrs_x60;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign rd_addr = (state_q == ST_MINS) ? tail_dec : tail_q;
  assign wr_en   = (state_q == ST_UPD) && push;
  assign div_ctrl.start = (state_q == ST_DIVS);

  always_comb begin
    state_d  = state_q;
    tail_d   = tail_q;
    count_d  = count_q;
    sum_d    = sum_q;
    secs_d   = secs_q;
    pct_d    = pct_q;
    status_d = status_q;
    mins_d   = mins_q;
    newest_d = newest_q;
    avg_d    = avg_q;
    hours_d  = hours_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          secs_d  = s_axis_tdata[PCT_W +: MAG_W];
          avg_d   = '0;
          hours_d = '0;
          if (!s_axis_tuser[0]) begin
            status_d = dmar_pkg::STATUS_UNAVAIL;
            pct_d    = '0;
            state_d  = ST_OUT;
          end else if (s_axis_tdata[PCT_W + dmar_pkg::SECS_W - 1]) begin
            status_d = dmar_pkg::STATUS_CHARGING;
            pct_d    = s_axis_tdata[PCT_W-1:0];
            state_d  = ST_OUT;
          end else begin
            status_d = dmar_pkg::STATUS_AVG;
            pct_d    = s_axis_tdata[PCT_W-1:0];
            state_d  = ST_MINS;
          end
        end
      end
      ST_MINS: begin
        mins_d  = product[dmar_pkg::RECIP_SHIFT +: MIN_W];
        state_d = ST_RDOL;
      end
      ST_RDOL: begin
        newest_d = rd_data_q;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        if (push) begin
          tail_d = tail_inc;
          if (full) begin
            sum_d = sum_q - SUM_W'(rd_data_q) + SUM_W'(mins_q);
          end else begin
            sum_d   = sum_q + SUM_W'(mins_q);
            count_d = count_q + 1'b1;
          end
        end
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_ctrl.done) begin
          avg_d   = div_quo[MIN_W-1:0];
          state_d = ST_HRS;
        end
      end
      ST_HRS: begin
        hours_d = product[dmar_pkg::RECIP_SHIFT +: HRS_W];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_user_d  = status_q;
      out_data_d  = {5'b0, min_rem[dmar_pkg::MINS_W-1:0], hours_q, pct_q};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tail_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q     <= secs_d;
    pct_q      <= pct_d;
    status_q   <= status_d;
    mins_q     <= mins_d;
    newest_q   <= newest_d;
    avg_q      <= avg_d;
    hours_q    <= hours_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // history ring, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[tail_q] <= mins_q;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `DMAR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(WINDOW_DEPTH),
    "history count above window depth")
  `DMAR_ASSERT_NOW(a_empty_sum, count_q == '0, sum_q == '0,
    "nonzero sum with empty history")
  `DMAR_ASSERT_NEXT(a_avg_nonempty, out_load && status_q == dmar_pkg::STATUS_AVG,
    count_q != '0, "average reported with empty history")

endmodule

/* design/dmar_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module dmar_div #(
  parameter int unsigned DW = 23,
  parameter int unsigned VW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* verif/tb.sv */
// testbench of the deduplicating runtime moving average, self-checking against a predictor
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH     = 10;
  localparam int unsigned N_RANDOM  = 1250;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned HOLD_AT   = 500;
  localparam int unsigned MAX_SECS  = 24'hFFFFFF;

  typedef struct packed {
    logic                        valid;
    logic [dmar_pkg::PCT_W-1:0]  pct;
    logic [dmar_pkg::SECS_W-1:0] secs;
  } reading_t;

  typedef struct packed {
    logic [dmar_pkg::STATUS_W-1:0] status;
    logic [dmar_pkg::PCT_W-1:0]    pct;
    logic [dmar_pkg::HRS_W-1:0]    hours;
    logic [dmar_pkg::MINS_W-1:0]   mins;
  } avg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // charge_percent, runtime_seconds, zero pad
  logic [0:0]  s_axis_tuser = '0;  // reading_valid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // percent_out, avg_hours, avg_minutes, zero pad
  logic [1:0]  m_axis_tuser;       // status

  reading_t    pending_readings[$];
  avg_result_t expected_averages[$];
  reading_t    offered_reading;
  avg_result_t oldest_average;

  logic [dmar_pkg::MIN_W-1:0] minutes_ring [DEPTH];
  int unsigned      minutes_sum = 0;
  int unsigned      live_count = 0;
  int unsigned      oldest_slot = 0;

  int unsigned readings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  dedup_moving_average_runtime #(
    .WINDOW_DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic avg_result_t predict_average(reading_t rd);
    avg_result_t res;
    logic [dmar_pkg::MIN_W-1:0] mins;
    int unsigned newest;
    int unsigned mean;
    res = '0;
    res.pct = rd.pct;
    if (!rd.valid) begin
      res.status = dmar_pkg::STATUS_UNAVAIL;
      res.pct = '0;
      return res;
    end
    if (rd.secs[dmar_pkg::SECS_W-1]) begin
      res.status = dmar_pkg::STATUS_CHARGING;
      return res;
    end
    mins = dmar_pkg::MIN_W'(rd.secs[dmar_pkg::SECS_MAG_W-1:0] / 60);
    newest = (oldest_slot + live_count + DEPTH - 1) % DEPTH;
    if (live_count == 0 || minutes_ring[newest] != mins) begin
      if (live_count < DEPTH) begin
        minutes_ring[(oldest_slot + live_count) % DEPTH] = mins;
        live_count++;
      end else begin
        minutes_sum -= minutes_ring[oldest_slot];
        minutes_ring[oldest_slot] = mins;
        oldest_slot = (oldest_slot + 1) % DEPTH;
      end
      minutes_sum += mins;
    end
    mean = minutes_sum / live_count;
    res.status = dmar_pkg::STATUS_AVG;
    res.hours = dmar_pkg::HRS_W'(mean / 60);
    res.mins = dmar_pkg::MINS_W'(mean % 60);
    return res;
  endfunction

  function automatic reading_t make_reading(logic valid, logic [dmar_pkg::PCT_W-1:0] pct,
                                            logic [dmar_pkg::SECS_W-1:0] secs);
    reading_t rd;
    rd.valid = valid;
    rd.pct = pct;
    rd.secs = secs;
    return rd;
  endfunction

  task automatic add_reading(logic valid, logic [dmar_pkg::PCT_W-1:0] pct,
                             logic [dmar_pkg::SECS_W-1:0] secs);
    pending_readings = {pending_readings, make_reading(valid, pct, secs)};
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_averages = {expected_averages, predict_average(offered_reading)};
        readings_sent++;
        tx_wait = ((readings_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 4);
      end
      if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_readings.size() != 0) begin
        offered_reading = pending_readings.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, offered_reading.secs, offered_reading.pct};
        s_axis_tuser <= offered_reading.valid;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: word with no expectation: status %0d tdata %h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          oldest_average = expected_averages.pop_front();
          if (m_axis_tuser != oldest_average.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     oldest_average.status, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata[7:0] != oldest_average.pct) begin
            $display("%0t: percent_out expected %0d actual %0d", $time,
                     oldest_average.pct, m_axis_tdata[7:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[20:8] != oldest_average.hours) begin
            $display("%0t: avg_hours expected %0d actual %0d", $time,
                     oldest_average.hours, m_axis_tdata[20:8]);
            mismatch_count++;
          end
          if (m_axis_tdata[26:21] != oldest_average.mins) begin
            $display("%0t: avg_minutes expected %0d actual %0d", $time,
                     oldest_average.mins, m_axis_tdata[26:21]);
            mismatch_count++;
          end
        end
        results_seen <= results_seen + 1;
        rx_wait = ((results_seen / 200) % 3 == 1) ? 0 : $urandom_range(0, 4);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      last_mins;
    logic [dmar_pkg::SECS_W-1:0] secs;
    logic             rd_valid;

    // failed reads, charging codes and out-of-range negatives
    add_reading(1'b0, 8'd255, 25'h1FFFFFF);
    add_reading(1'b0, 8'd0, 25'h0);
    add_reading(1'b1, 8'd255, 25'h1FFFFFF);
    add_reading(1'b1, 8'd0, 25'h1000000);
    add_reading(1'b1, 8'd100, 25'h1FFFFFE);
    // first entry, repeat within the same minute, minute boundary, extremes
    add_reading(1'b1, 8'd0, 25'd0);
    add_reading(1'b1, 8'd1, 25'd59);
    add_reading(1'b1, 8'd2, 25'd60);
    add_reading(1'b1, 8'd255, 25'(MAX_SECS));
    add_reading(1'b1, 8'd254, 25'(MAX_SECS));
    add_reading(1'b0, 8'd50, 25'd3600);
    // fill the ring past its depth so the oldest entries drop out
    for (int k = 1; k <= 11; k++) begin
      add_reading(1'b1, 8'(k * 9), 25'((k * 1237 + 5) * 60 + k));
    end
    // an old value that is not the newest is appended again
    add_reading(1'b1, 8'd77, 25'((3 * 1237 + 5) * 60));

    last_mins = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      rd_valid = 1'b1;
      if (pick < 8) begin
        rd_valid = 1'b0;
        secs = dmar_pkg::SECS_W'($urandom);
      end else if (pick < 16) begin
        secs = ($urandom_range(0, 1) == 1) ? 25'h1FFFFFF : {1'b1, 24'($urandom)};
      end else begin
        if (pick < 45) begin
          secs = dmar_pkg::SECS_W'(last_mins * 60 + $urandom_range(0, 59));
          if (secs > MAX_SECS) secs = dmar_pkg::SECS_W'(MAX_SECS);
        end else if (pick < 80) begin
          secs = dmar_pkg::SECS_W'($urandom_range(0, 36000));
        end else begin
          secs = {1'b0, 24'($urandom)};
        end
        last_mins = secs / 60;
      end
      add_reading(rd_valid, 8'($urandom), secs);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || s_axis_tvalid || expected_averages.size() != 0);
    repeat (64) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("** dedup_moving_average_runtime: PASSED **");
    end else begin
      $display("** dedup_moving_average_runtime: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("** dedup_moving_average_runtime: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/dmar_pkg.sv
design/dmar_div.sv
design/dedup_moving_average_runtime.sv
verif/tb.sv
